/* hw/rtl/bba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// shared codes and constants of the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int TAG_W = 5;
  localparam logic [TAG_W-1:0] TAG_FREE = 5'h1F;

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_FREE    = 2'd1;
  localparam logic [1:0] FUNC_REALLOC = 2'd2;
  localparam logic [1:0] FUNC_RESET   = 2'd3;

  localparam logic [2:0] STAT_GIVEN    = 3'd0;
  localparam logic [2:0] STAT_RELEASED = 3'd1;
  localparam logic [2:0] STAT_ZERO     = 3'd2;
  localparam logic [2:0] STAT_TOO_BIG  = 3'd3;
  localparam logic [2:0] STAT_NO_MEM   = 3'd4;
  localparam logic [2:0] STAT_NOT_ALLOC = 3'd5;
  localparam logic [2:0] STAT_POOL_RST = 3'd6;

  localparam logic [4:0] MIN_BLOCK_RESET = 5'd4;
  localparam logic REG_MIN_BLOCK = 1'b0;

endpackage

/* hw/rtl/bba_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/buddy_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator
// buddy allocator with per-level lifo free lists, link and tag rams
// ----------------------------------------------------------------------------
// alloc runs a level search, scans the free lists upward from the needed level,
//   pops a block, splits it down to the needed level and writes its tag; free
//   walks each level's list for the buddy through the single link ram read port
// one request at a time; a finished result waits until the output register is free
// reset and pool reset sweep all 2^POOL_LEVELS tag ram entries (1024 default)
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
  parameter int POOL_LEVELS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [31:0] request_bytes,
  input  logic        has_block,
  input  logic [25:0] block_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [25:0] result_offset,
  output logic [26:0] copy_bytes,
  output logic [25:0] old_offset,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NBLK = 1 << POOL_LEVELS;
  localparam int PW = POOL_LEVELS;
  localparam int IW = POOL_LEVELS + 1;
  localparam int HW = $clog2(POOL_LEVELS + 1);
  localparam int LW = $clog2(POOL_LEVELS + 2);
  localparam logic [IW-1:0] NIL = IW'(NBLK);
  localparam logic [LW-1:0] TOP = LW'(POOL_LEVELS);
  localparam logic [PW-1:0] CLR_LAST = PW'(NBLK - 1);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_CLEAR  = 12'b000000000010,
    S_TAGRD  = 12'b000000000100,
    S_LEVEL  = 12'b000000001000,
    S_SCAN   = 12'b000000010000,
    S_POP    = 12'b000000100000,
    S_SPLIT  = 12'b000001000000,
    S_RLS    = 12'b000010000000,
    S_RLSCHK = 12'b000100000000,
    S_WALK   = 12'b001000000000,
    S_WALKRD = 12'b010000000000,
    S_PUSH   = 12'b100000000000
  } state_t;

  state_t state;
  logic   fin;

  logic [4:0]    mbl;
  logic [IW-1:0] heads [0:POOL_LEVELS];
  logic [PW-1:0] clr;
  logic          respond;
  logic          op_alloc, op_free, op_realloc;
  logic [31:0]   req;
  logic [PW-1:0] idx, b, rb;
  logic [bba_pkg::TAG_W-1:0] old_tag;
  logic [LW-1:0] lvl, lcnt, cur, rl;
  logic [IW-1:0] prev, wcur, n;
  logic [2:0]    st;
  logic [25:0]   res_off, old_off;
  logic [26:0]   cp;

  // ram ports
  logic          tag_we, link_we;
  logic [PW-1:0] tag_waddr, tag_raddr, link_waddr, link_raddr;
  logic [bba_pkg::TAG_W-1:0] tag_wdata, tag_rdata;
  logic [IW-1:0] link_wdata, link_rdata;

  bba_ram #(.WIDTH(bba_pkg::TAG_W), .DEPTH(NBLK)) u_tag (
    .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
    .raddr(tag_raddr), .rdata(tag_rdata)
  );

  bba_ram #(.WIDTH(IW), .DEPTH(NBLK)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata)
  );

  function automatic logic [25:0] offset_of(input logic [PW-1:0] x, input logic [4:0] sh);
    logic [47:0] t;
    t = 48'(x) << sh;
    return t[25:0];
  endfunction

  // lookup of the request offset
  logic [25:0] lk_i;
  logic [31:0] lk_low;
  logic        lk_bad;
  assign lk_i   = block_offset >> mbl;
  assign lk_low = (32'd1 << mbl) - 32'd1;
  assign lk_bad = ((32'(block_offset) & lk_low) != 32'd0) || ((lk_i >> POOL_LEVELS) != 26'd0);

  // level search step
  logic [5:0]  e_lvl;
  logic        fits;
  logic [LW-1:0] lvl_val;
  assign e_lvl   = 6'(mbl) + 6'(lcnt);
  assign fits    = e_lvl[5] || ((33'd1 << e_lvl[4:0]) >= {1'b0, req});
  assign lvl_val = fits ? lcnt : TOP + LW'(1);

  // copy length of a realloc move
  logic [5:0]  e_cp;
  logic [32:0] osz;
  assign e_cp = 6'(mbl) + 6'(old_tag);
  assign osz  = 33'd1 << e_cp[4:0];

  logic [IW-1:0] cur_head;
  logic [LW-1:0] cur_m1;
  logic [PW-1:0] split_h;
  logic [PW-1:0] buddy;
  logic [IW-1:0] rl_head;
  assign cur_head = (cur <= TOP) ? heads[cur[HW-1:0]] : NIL;
  assign cur_m1   = cur - LW'(1);
  assign split_h  = b + (PW'(1) << cur_m1);
  assign buddy    = rb ^ (PW'(1) << rl);
  assign rl_head  = heads[rl[HW-1:0]];

  always_comb begin
    tag_we     = 1'b0;
    tag_waddr  = clr;
    tag_wdata  = bba_pkg::TAG_FREE;
    tag_raddr  = lk_i[PW-1:0];
    link_we    = 1'b0;
    link_waddr = '0;
    link_wdata = NIL;
    link_raddr = '0;
    case (state)
      S_CLEAR: begin
        tag_we  = 1'b1;
        link_we = (clr == '0);
      end
      S_SCAN: begin
        link_raddr = cur_head[PW-1:0];
      end
      S_SPLIT: begin
        if (cur > lvl) begin
          link_we    = 1'b1;
          link_waddr = split_h;
          link_wdata = heads[cur_m1[HW-1:0]];
        end else begin
          tag_we    = 1'b1;
          tag_waddr = b;
          tag_wdata = bba_pkg::TAG_W'(lvl);
        end
      end
      S_RLS: begin
        tag_we    = 1'b1;
        tag_waddr = rb;
      end
      S_WALK: begin
        link_raddr = wcur[PW-1:0];
      end
      S_WALKRD: begin
        if (wcur == {1'b0, buddy} && prev != NIL) begin
          link_we    = 1'b1;
          link_waddr = prev[PW-1:0];
          link_wdata = link_rdata;
        end
      end
      S_PUSH: begin
        link_we    = 1'b1;
        link_waddr = rb;
        link_wdata = rl_head;
      end
      default: ;
    endcase
  end

  // a finished request still waiting for the output register blocks the input
  assign in_stall = (state != S_IDLE) || fin;
  assign pready   = 1'b1;
  assign prdata   = {27'd0, mbl};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      fin       <= 1'b0;
      clr       <= '0;
      respond   <= 1'b0;
      out_valid <= 1'b0;
      mbl       <= bba_pkg::MIN_BLOCK_RESET;
      for (int i = 0; i <= POOL_LEVELS; i++) begin
        heads[i] <= (i == POOL_LEVELS) ? IW'(0) : NIL;
      end
    end else begin
      if (psel && penable && pwrite && paddr[2] == bba_pkg::REG_MIN_BLOCK) begin
        mbl <= pwdata[4:0];
      end

      // finished request waits here until the output register is free
      if (fin && (!out_valid || !out_stall)) begin
        fin           <= 1'b0;
        out_valid     <= 1'b1;
        status        <= st;
        result_offset <= res_off;
        copy_bytes    <= cp;
        old_offset    <= old_off;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid && !fin) begin
            req        <= request_bytes;
            idx        <= lk_i[PW-1:0];
            rb         <= lk_i[PW-1:0];
            res_off    <= '0;
            cp         <= '0;
            old_off    <= '0;
            lcnt       <= '0;
            op_alloc   <= (func == bba_pkg::FUNC_ALLOC) ||
                          (func == bba_pkg::FUNC_REALLOC && !has_block);
            op_free    <= (func == bba_pkg::FUNC_FREE);
            op_realloc <= (func == bba_pkg::FUNC_REALLOC && has_block);
            if (func == bba_pkg::FUNC_RESET) begin
              for (int i = 0; i <= POOL_LEVELS; i++) begin
                heads[i] <= (i == POOL_LEVELS) ? IW'(0) : NIL;
              end
              st      <= bba_pkg::STAT_POOL_RST;
              clr     <= '0;
              respond <= 1'b1;
              state   <= S_CLEAR;
            end else if (func == bba_pkg::FUNC_ALLOC ||
                         (func == bba_pkg::FUNC_REALLOC && !has_block)) begin
              if (request_bytes == 32'd0) begin
                st  <= bba_pkg::STAT_ZERO;
                fin <= 1'b1;
              end else begin
                state <= S_LEVEL;
              end
            end else if (func == bba_pkg::FUNC_FREE && !has_block) begin
              st  <= bba_pkg::STAT_RELEASED;
              fin <= 1'b1;
            end else if (lk_bad) begin
              st  <= bba_pkg::STAT_NOT_ALLOC;
              fin <= 1'b1;
            end else begin
              state <= S_TAGRD;
            end
          end
        end
        S_CLEAR: begin
          clr <= clr + PW'(1);
          if (clr == CLR_LAST) begin
            state <= S_IDLE;
            if (respond) begin
              fin <= 1'b1;
            end
            respond <= 1'b0;
          end
        end
        S_TAGRD: begin
          old_tag <= tag_rdata;
          rl      <= LW'(tag_rdata);
          if (tag_rdata > bba_pkg::TAG_W'(POOL_LEVELS)) begin
            st    <= bba_pkg::STAT_NOT_ALLOC;
            fin   <= 1'b1;
            state <= S_IDLE;
          end else if (op_free || req == 32'd0) begin
            st    <= bba_pkg::STAT_RELEASED;
            state <= S_RLS;
          end else begin
            state <= S_LEVEL;
          end
        end
        S_LEVEL: begin
          if (fits || lcnt == TOP) begin
            lvl <= lvl_val;
            cur <= lvl_val;
            if (op_realloc && bba_pkg::TAG_W'(lvl_val) <= old_tag) begin
              st      <= bba_pkg::STAT_GIVEN;
              res_off <= offset_of(idx, mbl);
              fin     <= 1'b1;
              state   <= S_IDLE;
            end else if (lvl_val > TOP) begin
              st    <= bba_pkg::STAT_TOO_BIG;
              fin   <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_SCAN;
            end
          end else begin
            lcnt <= lcnt + LW'(1);
          end
        end
        S_SCAN: begin
          if (cur > TOP) begin
            st    <= bba_pkg::STAT_NO_MEM;
            fin   <= 1'b1;
            state <= S_IDLE;
          end else if (cur_head == NIL) begin
            cur <= cur + LW'(1);
          end else begin
            b     <= cur_head[PW-1:0];
            state <= S_POP;
          end
        end
        S_POP: begin
          heads[cur[HW-1:0]] <= link_rdata;
          state <= S_SPLIT;
        end
        S_SPLIT: begin
          if (cur > lvl) begin
            heads[cur_m1[HW-1:0]] <= {1'b0, split_h};
            cur <= cur_m1;
          end else begin
            st      <= bba_pkg::STAT_GIVEN;
            res_off <= offset_of(b, mbl);
            if (op_realloc) begin
              old_off <= offset_of(idx, mbl);
              if (e_cp[5] || osz >= {1'b0, req}) begin
                cp <= req[26:0];
              end else begin
                cp <= osz[26:0];
              end
              state <= S_RLS;
            end else begin
              fin   <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_RLS: begin
          state <= S_RLSCHK;
        end
        S_RLSCHK: begin
          if (rl < TOP) begin
            prev  <= NIL;
            wcur  <= rl_head;
            n     <= '0;
            state <= S_WALK;
          end else begin
            state <= S_PUSH;
          end
        end
        S_WALK: begin
          if (!wcur[PW] && !n[PW]) begin
            state <= S_WALKRD;
          end else begin
            state <= S_PUSH;
          end
        end
        S_WALKRD: begin
          if (wcur == {1'b0, buddy}) begin
            if (prev == NIL) begin
              heads[rl[HW-1:0]] <= link_rdata;
            end
            if (buddy < rb) begin
              rb <= buddy;
            end
            rl    <= rl + LW'(1);
            state <= S_RLSCHK;
          end else begin
            prev  <= wcur;
            wcur  <= link_rdata;
            n     <= n + IW'(1);
            state <= S_WALK;
          end
        end
        S_PUSH: begin
          heads[rl[HW-1:0]] <= {1'b0, rb};
          fin   <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/bba_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_checker
// port level checks of the buddy block allocator
// ----------------------------------------------------------------------------
module bba_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [25:0] result_offset,
  input logic [26:0] copy_bytes
);

  // tag sweep after reset keeps requests out
  a_sweep: assert property (@(posedge clk) rst |=> in_stall && !out_valid)
    else $error("requests taken during reset sweep");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_offset))
    else $error("stalled result changed");

  a_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bba_pkg::STAT_GIVEN |-> result_offset == 26'd0 &&
    copy_bytes == 27'd0)
    else $error("offset reported without a block");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 3'd7)
    else $error("undefined status code");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);
